@@ rtl/core/shqr_pkg.sv @@
`timescale 1ns / 1ps

package shqr_pkg;

    // Field widths and defaults
    localparam int CNT_W       = 13;
    localparam int CNT_MAX     = 8191;
    localparam int MAX_LEN_DEF = 4096;
    localparam int MAX_RES     = 3;

    // Result queue depth, a power of two
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = 3;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // One output word
    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             end_of_token;
        logic             stopped_on_space;
        logic [CNT_W-1:0] consumed;
    } res_t;

    // Up to three output words made by one input byte
    typedef struct packed {
        res_t [MAX_RES-1:0] item;
        logic [1:0]         n;
    } res_bundle_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER);
    endfunction

    // Append one word to a bundle; drop it when the bundle is full
    function automatic res_bundle_t put(input res_bundle_t b, input logic [7:0] by,
                                        input logic v);
        res_bundle_t r;
        r = b;
        if (b.n < 2'(MAX_RES))
        begin
            r.item[b.n].out_byte         = by;
            r.item[b.n].byte_valid       = v;
            r.item[b.n].end_of_token     = 1'b0;
            r.item[b.n].stopped_on_space = 1'b0;
            r.item[b.n].consumed         = '0;
            r.n = b.n + 2'd1;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/shell_quote_removal_stream.sv @@
`timescale 1ns / 1ps

// Quote removal on a stream of command-line bytes.
// Input channel: in_valid / in_stall carry char_in and last_in, one byte per word;
// last_in marks the final byte of a line. Output channel: out_valid / out_stall
// carry out_byte, byte_valid, end_of_token, stopped_on_space and consumed.
// Each input byte yields zero to three output words. The front classifies the
// byte in the cycle it is accepted and writes its words into an 8-entry queue,
// whose registered head word drives the output.
// Throughput is one input byte per cycle while in_stall is low; in_stall rises
// whenever fewer than three queue entries are free, so bytes that yield words
// faster than the receiver takes them back up the input.
// A stalled receiver holds the head word stable and lets the queue fill.
// cfg_we / cfg_wdata write word_mode; write it only while the block is idle.
// Reset clears the quote state, the byte count, word_mode and the queue.
module shell_quote_removal_stream
    import shqr_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       char_in,
    input  logic             last_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             end_of_token,
    output logic             stopped_on_space,
    output logic [CNT_W-1:0] consumed
);

    res_bundle_t push;
    logic        full;
    logic        acc;

    // Accept a byte when the queue can take a full bundle
    assign in_stall = full;
    assign acc      = in_valid && !full;

    shqr_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .acc       (acc),
        .char_in   (char_in),
        .last_in   (last_in),
        .push      (push)
    );

    shqr_queue u_queue (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .byte_valid       (byte_valid),
        .end_of_token     (end_of_token),
        .stopped_on_space (stopped_on_space),
        .consumed         (consumed)
    );

endmodule

@@ rtl/core/shqr_front.sv @@
`timescale 1ns / 1ps

module shqr_front
    import shqr_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        acc,
    input  logic [7:0]  char_in,
    input  logic        last_in,
    output res_bundle_t push
);

    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'((MAX_LEN < CNT_MAX) ? MAX_LEN : CNT_MAX);

    typedef struct packed {
        logic in_s;
        logic in_d;
        logic dp_set;
        logic stop;
        logic emit;
    } plain_t;

    logic             word_mode_reg;
    logic             in_s_reg, in_s_next;
    logic             in_d_reg, in_d_next;
    logic             dp_reg, dp_next;
    logic             nm_reg, nm_next;
    logic             st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    res_bundle_t      bnd;

    // Ordinary handling of one byte against the quote state
    function automatic plain_t plain(input logic [7:0] c, input logic last,
                                     input logic s_in, input logic d_in, input logic wm);
        plain_t p;
        p = '0;
        p.in_s = s_in;
        p.in_d = d_in;
        if ((c == CH_DQUOTE) && !p.in_s)
            p.in_d = !p.in_d;
        if ((c == CH_SQUOTE) && !p.in_d)
            p.in_s = !p.in_s;
        if (!p.in_s && !p.in_d && is_ws(c))
        begin
            if (wm)
                p.stop = 1'b1;
            else
                p.emit = 1'b1;
        end
        else if (((c == CH_DQUOTE) && p.in_s) || ((c == CH_SQUOTE) && p.in_d))
            p.emit = 1'b1;
        else if ((c == CH_DOLLAR) && !p.in_s)
        begin
            if (last)
                p.emit = 1'b1;
            else
                p.dp_set = 1'b1;
        end
        else if ((c != CH_SQUOTE) && (c != CH_DQUOTE))
            p.emit = 1'b1;
        return p;
    endfunction

    // Classify the byte and build its output words
    always_comb
    begin
        plain_t     p;
        logic       use_plain;
        logic       inc;
        logic       stop;
        logic [1:0] last_idx;

        p         = '0;
        use_plain = 1'b0;
        inc       = 1'b0;
        stop      = 1'b0;
        bnd       = '0;
        last_idx  = '0;
        in_s_next = in_s_reg;
        in_d_next = in_d_reg;
        dp_next   = dp_reg;
        nm_next   = nm_reg;
        st_next   = st_reg;
        cnt_next  = cnt_reg;

        if (st_reg)
        begin
            // skip bytes after a word stop until end of line
            if (last_in)
            begin
                in_s_next = 1'b0;
                in_d_next = 1'b0;
                dp_next   = 1'b0;
                nm_next   = 1'b0;
                st_next   = 1'b0;
                cnt_next  = '0;
            end
        end
        else
        begin
            if (dp_reg)
            begin
                dp_next = 1'b0;
                if (is_digit(char_in))
                    inc = 1'b1;
                else if (is_ws(char_in) || (char_in == CH_DOLLAR))
                begin
                    bnd = put(bnd, CH_DOLLAR, 1'b1);
                    use_plain = 1'b1;
                end
                else if (is_name(char_in))
                begin
                    bnd = put(bnd, CH_DQUOTE, 1'b1);
                    bnd = put(bnd, char_in, 1'b1);
                    inc = 1'b1;
                    if (last_in)
                        bnd = put(bnd, CH_DQUOTE, 1'b1);
                    else
                        nm_next = 1'b1;
                end
                else
                begin
                    bnd = put(bnd, CH_DQUOTE, 1'b1);
                    bnd = put(bnd, CH_DQUOTE, 1'b1);
                    use_plain = 1'b1;
                end
            end
            else if (nm_reg)
            begin
                if (is_name(char_in))
                begin
                    bnd = put(bnd, char_in, 1'b1);
                    inc = 1'b1;
                    if (last_in)
                    begin
                        bnd = put(bnd, CH_DQUOTE, 1'b1);
                        nm_next = 1'b0;
                    end
                end
                else
                begin
                    nm_next = 1'b0;
                    bnd = put(bnd, CH_DQUOTE, 1'b1);
                    use_plain = 1'b1;
                end
            end
            else
                use_plain = 1'b1;

            // run the byte through the quote logic
            if (use_plain)
            begin
                p = plain(char_in, last_in, in_s_reg, in_d_reg, word_mode_reg);
                in_s_next = p.in_s;
                in_d_next = p.in_d;
                if (p.dp_set)
                    dp_next = 1'b1;
                if (p.emit)
                    bnd = put(bnd, char_in, 1'b1);
                stop = p.stop;
                inc  = !p.stop;
            end

            if (inc && (cnt_reg < CNT_CAP))
                cnt_next = cnt_reg + CNT_W'(1);

            // mark the end of the token
            if (stop || last_in)
            begin
                if (bnd.n == 2'd0)
                    bnd = put(bnd, 8'h00, 1'b0);
                last_idx = bnd.n - 2'd1;
                bnd.item[last_idx].end_of_token     = 1'b1;
                bnd.item[last_idx].stopped_on_space = stop;
                bnd.item[last_idx].consumed         = cnt_next;
                if (last_in)
                begin
                    in_s_next = 1'b0;
                    in_d_next = 1'b0;
                    dp_next   = 1'b0;
                    nm_next   = 1'b0;
                    st_next   = 1'b0;
                    cnt_next  = '0;
                end
                else
                    st_next = 1'b1;
            end
        end
    end

    // Hand words to the queue only for an accepted byte
    always_comb
    begin
        push = bnd;
        if (!acc)
            push.n = 2'd0;
    end

    // Hold configuration and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_mode_reg <= 1'b0;
            in_s_reg      <= 1'b0;
            in_d_reg      <= 1'b0;
            dp_reg        <= 1'b0;
            nm_reg        <= 1'b0;
            st_reg        <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                word_mode_reg <= cfg_wdata;
            if (acc)
            begin
                in_s_reg <= in_s_next;
                in_d_reg <= in_d_next;
                dp_reg   <= dp_next;
                nm_reg   <= nm_next;
                st_reg   <= st_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_dollar_in_name: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_reg && nm_reg))
        else $error("dollar pending while inside a name");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_CAP)
        else $error("byte count above its cap");

    a_quiet_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && st_reg) |-> (push.n == 2'd0))
        else $error("words produced after a word stop");

    a_stop_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !st_reg && st_next) |-> word_mode_reg)
        else $error("token stopped without word mode");
`endif

endmodule

@@ rtl/core/shqr_queue.sv @@
`timescale 1ns / 1ps

module shqr_queue
    import shqr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  res_bundle_t      push,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             end_of_token,
    output logic             stopped_on_space,
    output logic [CNT_W-1:0] consumed
);

    res_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic            pop;
    res_t            head;

    // Stall the front unless a full bundle fits
    assign full      = (cnt_reg > (Q_AW+1)'(Q_DEPTH - MAX_RES));
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;

    // Present the head word
    assign head             = mem[rd_ptr_reg];
    assign out_byte         = head.out_byte;
    assign byte_valid       = head.byte_valid;
    assign end_of_token     = head.end_of_token;
    assign stopped_on_space = head.stopped_on_space;
    assign consumed         = head.consumed;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_AW'(push.n);
        rd_ptr_next = rd_ptr_reg + Q_AW'(pop);
        cnt_next    = cnt_reg + (Q_AW+1)'(push.n) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write up to three words in one cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (2'(i) < push.n)
                mem[wr_ptr_reg + Q_AW'(i)] <= push.item[i];
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ((Q_AW+2)'(cnt_reg) + (Q_AW+2)'(push.n)) <= (Q_AW+2)'(Q_DEPTH))
        else $error("result queue overflow");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue level out of range");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push.n == 2'd0)) |=> (cnt_reg == $past(cnt_reg) - (Q_AW+1)'(1)))
        else $error("pop did not lower the level");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != (Q_AW+1)'(Q_DEPTH)) |-> (Q_AW'(wr_ptr_reg - rd_ptr_reg) == cnt_reg[Q_AW-1:0]))
        else $error("pointers disagree with level");
`endif

endmodule

@@ sim/shell_quote_removal_stream_tb.sv @@
`timescale 1ns / 1ps

module shell_quote_removal_stream_tb;
    import shqr_pkg::*;

    localparam int COUNT_CAP      = (MAX_LEN_DEF < CNT_MAX) ? MAX_LEN_DEF : CNT_MAX;
    localparam int TAIL_CYCLES    = 16;
    localparam int RAND_PER_PHASE = 100;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         typed;
        res_t       want;
    } stim_row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_wdata = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [7:0]       char_in   = 8'h00;
    logic             last_in   = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             end_of_token;
    logic             stopped_on_space;
    logic [CNT_W-1:0] consumed;

    // Line state of the predictor
    bit               pred_word_mode = 1'b0;
    bit               in_sq          = 1'b0;
    bit               in_dq          = 1'b0;
    bit               dollar_wait    = 1'b0;
    bit               in_ident       = 1'b0;
    bit               line_stopped   = 1'b0;
    logic [CNT_W-1:0] line_count     = '0;

    // Words made by the byte under prediction
    res_t             step_w [MAX_RES];
    int               step_n;

    res_t             token_words_q [$];
    res_t             next_word;
    stim_row_t        dir_rows [$];
    int               split_at;
    int               bad_words  = 0;
    int               burst_left = 0;
    int               live_items = 0;
    int               stall_mode = 0;
    int               stall_left = 0;

    shell_quote_removal_stream u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_in          (char_in),
        .last_in          (last_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .byte_valid       (byte_valid),
        .end_of_token     (end_of_token),
        .stopped_on_space (stopped_on_space),
        .consumed         (consumed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Character classes
    function automatic bit is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic bit is_ident(input logic [7:0] c);
        return is_num(c) || ((c >= 8'h41) && (c <= 8'h5A))
            || ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDER);
    endfunction

    function automatic void clear_line();
        in_sq        = 1'b0;
        in_dq        = 1'b0;
        dollar_wait  = 1'b0;
        in_ident     = 1'b0;
        line_stopped = 1'b0;
        line_count   = '0;
    endfunction

    // Count a consumed byte; saturate at the cap
    function automatic void bump_count();
        if (line_count < COUNT_CAP)
            line_count = line_count + 1'b1;
    endfunction

    function automatic void push_word(input logic [7:0] b, input logic v);
        res_t w;
        w            = '0;
        w.out_byte   = b;
        w.byte_valid = v;
        if (step_n < MAX_RES)
        begin
            step_w[step_n] = w;
            step_n++;
        end
    endfunction

    // Ordinary quote handling of one byte; returns 1 on a word-mode stop
    function automatic bit take_plain(input logic [7:0] c, input bit l);
        if (c == CH_DQUOTE && !in_sq)
            in_dq = !in_dq;
        if (c == CH_SQUOTE && !in_dq)
            in_sq = !in_sq;
        if (!in_sq && !in_dq && is_blank(c))
        begin
            if (pred_word_mode)
                return 1'b1;
            push_word(c, 1'b1);
        end
        else if ((c == CH_DQUOTE && in_sq) || (c == CH_SQUOTE && in_dq))
            push_word(c, 1'b1);
        else if (c == CH_DOLLAR && !in_sq)
        begin
            if (l)
                push_word(c, 1'b1);
            else
                dollar_wait = 1'b1;
        end
        else if (c != CH_SQUOTE && c != CH_DQUOTE)
            push_word(c, 1'b1);
        bump_count();
        return 1'b0;
    endfunction

    // Predict the words of one accepted byte into step_w; returns 1 if ignored
    function automatic bit rewrite_byte(input logic [7:0] c, input bit l);
        bit stop;
        stop   = 1'b0;
        step_n = 0;
        if (line_stopped)
        begin
            if (l)
                clear_line();
            return 1'b1;
        end
        if (dollar_wait)
        begin
            dollar_wait = 1'b0;
            if (is_num(c))
                bump_count();
            else if (is_blank(c) || c == CH_DOLLAR)
            begin
                push_word(CH_DOLLAR, 1'b1);
                stop = take_plain(c, l);
            end
            else if (is_ident(c))
            begin
                push_word(CH_DQUOTE, 1'b1);
                push_word(c, 1'b1);
                bump_count();
                if (l)
                    push_word(CH_DQUOTE, 1'b1);
                else
                    in_ident = 1'b1;
            end
            else
            begin
                push_word(CH_DQUOTE, 1'b1);
                push_word(CH_DQUOTE, 1'b1);
                stop = take_plain(c, l);
            end
        end
        else if (in_ident)
        begin
            if (is_ident(c))
            begin
                push_word(c, 1'b1);
                bump_count();
                if (l)
                begin
                    push_word(CH_DQUOTE, 1'b1);
                    in_ident = 1'b0;
                end
            end
            else
            begin
                in_ident = 1'b0;
                push_word(CH_DQUOTE, 1'b1);
                stop = take_plain(c, l);
            end
        end
        else
            stop = take_plain(c, l);

        // Mark the end of the token on the last word, or on a bare marker
        if (stop || l)
        begin
            if (step_n == 0)
                push_word(8'h00, 1'b0);
            step_w[step_n-1].end_of_token     = 1'b1;
            step_w[step_n-1].stopped_on_space = stop;
            step_w[step_n-1].consumed         = line_count;
            if (l)
                clear_line();
            else
                line_stopped = 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic res_t mark(input logic [7:0] b, input logic v, input logic s,
                                  input logic [CNT_W-1:0] n);
        res_t w;
        w.out_byte         = b;
        w.byte_valid       = v;
        w.end_of_token     = 1'b1;
        w.stopped_on_space = s;
        w.consumed         = n;
        return w;
    endfunction

    function automatic void add_row(input logic [7:0] c, input logic l,
                                    input bit typed = 1'b0, input res_t want = '0);
        stim_row_t r;
        r.ch    = c;
        r.last  = l;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    // Random byte leaning toward quotes, dollars, names and whitespace
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1: return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
            2: return 8'h30 + 8'($urandom_range(0, 9));
            3: return CH_DOLLAR;
            4: return CH_SQUOTE;
            5: return CH_DQUOTE;
            6: return $urandom_range(0, 1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
            7: return CH_UNDER;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one byte, hold it until accepted, predict, then maybe idle
    task automatic send_byte(input logic [7:0] c, input logic l,
                             input bit typed = 1'b0, input res_t want = '0);
        bit skipped;
        int gap;
        in_valid <= 1'b1;
        char_in  <= c;
        last_in  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        skipped = rewrite_byte(c, l);
        if (typed)
            token_words_q.push_back(want);
        else
            for (int i = 0; i < step_n; i++)
                token_words_q.push_back(step_w[i]);
        if (!skipped)
            live_items++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid, wait for every expected word, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (token_words_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_word_mode(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we         <= 1'b0;
        pred_word_mode = v;
    endtask

    task automatic send_line(input int len, input bit noise);
        logic [7:0] c;
        for (int i = 0; i < len; i++)
        begin
            c = noise ? 8'($urandom_range(0, 255)) : pick_char();
            send_byte(c, i == len - 1);
        end
    endtask

    // Random lines until enough bytes were not ignored
    task automatic run_phase(input int target);
        int len;
        live_items = 0;
        while (live_items < target)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                in_valid <= 1'b0;
                while (token_words_q.size() != 0)
                    @(posedge clk);
            end
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            send_line(len, $urandom_range(0, 9) == 0);
        end
    endtask

    // Check each accepted word and drive the receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (token_words_q.size() == 0)
            begin
                $error("unexpected word: out_byte %h end_of_token %b", out_byte, end_of_token);
                bad_words++;
            end
            else
            begin
                next_word = token_words_q.pop_front();
                if (out_byte !== next_word.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", next_word.out_byte, out_byte);
                    bad_words++;
                end
                if (byte_valid !== next_word.byte_valid)
                begin
                    $error("byte_valid: expected %b, got %b", next_word.byte_valid, byte_valid);
                    bad_words++;
                end
                if (end_of_token !== next_word.end_of_token)
                begin
                    $error("end_of_token: expected %b, got %b",
                           next_word.end_of_token, end_of_token);
                    bad_words++;
                end
                if (stopped_on_space !== next_word.stopped_on_space)
                begin
                    $error("stopped_on_space: expected %b, got %b",
                           next_word.stopped_on_space, stopped_on_space);
                    bad_words++;
                end
                if (consumed !== next_word.consumed)
                begin
                    $error("consumed: expected %0d, got %0d", next_word.consumed, consumed);
                    bad_words++;
                end
            end
        end

        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 120);
        end
        else
            stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Hard stop for a hung run
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        // Quote removal with word mode off
        add_row(8'h61, 1'b1, 1'b1, mark(8'h61, 1'b1, 1'b0, 13'd1));
        add_row(8'h00, 1'b1, 1'b1, mark(8'h00, 1'b1, 1'b0, 13'd1));
        add_row(8'hFF, 1'b1, 1'b1, mark(8'hFF, 1'b1, 1'b0, 13'd1));
        add_row(CH_DQUOTE, 1'b1, 1'b1, mark(8'h00, 1'b0, 1'b0, 13'd1));
        add_row(CH_SQUOTE, 1'b0);
        add_row(CH_DQUOTE, 1'b0);
        add_row(CH_SQUOTE, 1'b1);
        add_row(CH_DOLLAR, 1'b0);
        add_row(8'h35, 1'b1);
        add_row(CH_DOLLAR, 1'b0);
        add_row(CH_DOLLAR, 1'b1);
        add_row(CH_DOLLAR, 1'b0);
        add_row(8'h78, 1'b0);
        add_row(8'h2D, 1'b1);
        add_row(CH_DOLLAR, 1'b0);
        add_row(8'h21, 1'b1);
        add_row(CH_DOLLAR, 1'b1);
        add_row(CH_DQUOTE, 1'b0);
        add_row(CH_DOLLAR, 1'b0);
        add_row(8'h61, 1'b1);
        add_row(CH_SQUOTE, 1'b0);
        add_row(CH_DOLLAR, 1'b1);
        split_at = dir_rows.size();
        // Word mode: stop at whitespace, then ignore the rest of the line
        add_row(CH_SPACE, 1'b0, 1'b1, mark(8'h00, 1'b0, 1'b1, 13'd0));
        add_row(8'h71, 1'b1);
        add_row(8'h61, 1'b0);
        add_row(CH_DOLLAR, 1'b0);
        add_row(CH_SPACE, 1'b0);
        add_row(8'h62, 1'b1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_word_mode(1'b0);
        foreach (dir_rows[i])
        begin
            if (i == split_at)
            begin
                settle();
                set_word_mode(1'b1);
            end
            send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < 4; p++)
        begin
            settle();
            set_word_mode(p % 2 == 1);
            run_phase(RAND_PER_PHASE);
        end

        settle();
        if (bad_words == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ shell_quote_removal_stream.f @@
rtl/core/shqr_pkg.sv
rtl/core/shqr_front.sv
rtl/core/shqr_queue.sv
rtl/core/shell_quote_removal_stream.sv
sim/shell_quote_removal_stream_tb.sv
